[rtl/nrf_pkg.sv]
package nrf_pkg;

    localparam int MAX_POINTS_DEF = 512;

    localparam int KIND_W     = 2;
    localparam int COORD_W    = 16;
    localparam int PT_W       = 2 * COORD_W;
    localparam int RADIUS_W   = 12;
    localparam int LIM_W      = 2 * RADIUS_W;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int SUM_W      = SQ_W + 1;
    localparam int ID_W       = 24;
    localparam int KEPT_W     = 10;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_ID = 8'd1;

    // 15 pixels in 1/16 pixel
    localparam logic [RADIUS_W-1:0] RADIUS_RST   = 12'd240;
    localparam logic [ID_W-1:0]     FIRST_ID_RST = 24'd0;

    typedef struct packed {
        logic valid;
        logic hit;
        logic busy;
    } dist_res_t;

endpackage

[rtl/nrf_ifs.sv]
interface nrf_item_if import nrf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;

    modport source (output valid, kind, pos_x, pos_y, input ready);
    modport sink   (input valid, kind, pos_x, pos_y, output ready);
endinterface

interface nrf_result_if import nrf_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            keep;
    logic [ID_W-1:0] new_id;

    modport source (output valid, keep, new_id, input ready);
    modport sink   (input valid, keep, new_id, output ready);
endinterface

interface nrf_cfg_if import nrf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/new_feature_radius_filter.sv]
// channel | role   | word
// --------+--------+----------------------------------------
// item    | sink   | kind, pos_x, pos_y
// result  | source | keep, new_id (one per query)
// cfg     | sink   | index, data (0 radius, 1 first id)
//
// Clear and load words are taken without leaving idle; kind 3 is accepted and dropped.
// A query holds the input until its result is registered; during its scan
// the point table's single read port feeds one stored point per cycle into the
// pipelined distance unit. A query stops reading at the first hit, then drains.
// Reset clears counters and state and loads the cfg defaults; table contents are not cleared.
// The result register lets the next word in while a result waits; a query
// finishing into a full result register holds until it is taken.
module new_feature_radius_filter import nrf_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    nrf_item_if.sink    item,
    nrf_result_if.source result,
    nrf_cfg_if.sink     cfg
);

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    issue_reg;
    logic [KEPT_W-1:0]   kept_reg;
    logic [RADIUS_W-1:0] radius_reg;
    logic [ID_W-1:0]     first_id_reg;
    logic [LIM_W-1:0]    limit_reg;
    logic [COORD_W-1:0]  qx_reg;
    logic [COORD_W-1:0]  qy_reg;
    logic                near_reg;
    logic                rd_valid_reg;
    logic                out_valid_reg;
    logic                out_keep_reg;
    logic [ID_W-1:0]     out_id_reg;

    logic                accept;
    logic                wr_en;
    logic                rd_en;
    logic                scan_done;
    logic                out_free;
    logic [PT_W-1:0]     rd_data;
    dist_res_t           dres;

    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;
    assign wr_en      = accept && (item.kind == KIND_LOAD) && (count_reg < CNT_MAX);
    assign rd_en      = (state_reg == ST_SCAN) && (issue_reg < count_reg) && !near_reg;
    assign scan_done  = (state_reg == ST_SCAN) && !rd_en && !rd_valid_reg && !dres.busy;
    assign out_free   = !out_valid_reg || result.ready;

    nrf_mem #(
        .DEPTH (MAX_POINTS)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data ({item.pos_y, item.pos_x}),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    nrf_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rd_valid_reg),
        .entry    (rd_data),
        .qx       (qx_reg),
        .qy       (qy_reg),
        .limit    (limit_reg),
        .res      (dres)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.kind == KIND_QUERY))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            kept_reg      <= '0;
            radius_reg    <= RADIUS_RST;
            first_id_reg  <= FIRST_ID_RST;
            near_reg      <= 1'b0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_en;

            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_RADIUS)
                begin
                    radius_reg <= cfg.data[RADIUS_W-1:0];
                end
                else if (cfg.index == REG_FIRST_ID)
                begin
                    first_id_reg <= cfg.data[ID_W-1:0];
                end
            end

            if (accept && (item.kind == KIND_CLEAR))
            begin
                count_reg <= '0;
                kept_reg  <= '0;
            end
            if (wr_en)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (accept && (item.kind == KIND_QUERY))
            begin
                issue_reg <= '0;
                near_reg  <= 1'b0;
            end

            if (rd_en)
            begin
                issue_reg <= issue_reg + CNT_W'(1);
            end
            if (dres.valid && dres.hit)
            begin
                near_reg <= 1'b1;
            end

            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (!near_reg)
                begin
                    kept_reg <= kept_reg + KEPT_W'(1);
                end
            end
            else if (result.valid && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (item.kind == KIND_QUERY))
        begin
            qx_reg    <= item.pos_x;
            qy_reg    <= item.pos_y;
            limit_reg <= LIM_W'(radius_reg) * LIM_W'(radius_reg);
        end
        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_keep_reg <= !near_reg;
            out_id_reg   <= near_reg ? '0 : first_id_reg + ID_W'(kept_reg);
        end
    end

    assign cfg.ready     = 1'b1;
    assign result.valid  = out_valid_reg;
    assign result.keep   = out_keep_reg;
    assign result.new_id = out_id_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("tracked count beyond table depth");

    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg) == ST_FINISH)
        else $error("result raised outside finish");

    a_query_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (item.kind == KIND_QUERY) |=> state_reg == ST_SCAN)
        else $error("query did not start a scan");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> issue_reg < count_reg && $stable(count_reg))
        else $error("table read past tracked count");
`endif

endmodule

[rtl/nrf_mem.sv]
module nrf_mem import nrf_pkg::*; #(
    parameter int DEPTH = MAX_POINTS_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [PT_W-1:0]          wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [PT_W-1:0]          rd_data
);

    logic [PT_W-1:0] mem [DEPTH];
    logic [PT_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/nrf_dist.sv]
module nrf_dist import nrf_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [PT_W-1:0]    entry,
    input  logic [COORD_W-1:0] qx,
    input  logic [COORD_W-1:0] qy,
    input  logic [LIM_W-1:0]   limit,
    output dist_res_t          res
);

    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
    logic [COORD_W-1:0] dx_next;
    logic [COORD_W-1:0] dy_next;
    logic [COORD_W-1:0] dx_reg;
    logic [COORD_W-1:0] dy_reg;
    logic [SQ_W-1:0]    sqx_reg;
    logic [SQ_W-1:0]    sqy_reg;
    logic [SUM_W-1:0]   sum;
    logic               hit_reg;
    logic               v1_reg;
    logic               v2_reg;
    logic               v3_reg;

    // entry: y in the upper half, x in the lower half
    assign ex = entry[COORD_W-1:0];
    assign ey = entry[PT_W-1:COORD_W];

    always_comb
    begin
        dx_next = (ex >= qx) ? ex - qx : qx - ex;
        dy_next = (ey >= qy) ? ey - qy : qy - ey;
        sum     = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= dx_next;
        dy_reg  <= dy_next;
        sqx_reg <= dx_reg * dx_reg;
        sqy_reg <= dy_reg * dy_reg;
        hit_reg <= (sum <= {{(SUM_W-LIM_W){1'b0}}, limit});
    end

    assign res.valid = v3_reg;
    assign res.hit   = hit_reg;
    assign res.busy  = v1_reg | v2_reg | v3_reg;

endmodule
